/* hw/rtl/lru_pkg.sv */
package lru_pkg;

  localparam int PAGE_W          = 32;
  localparam int COUNT_W         = 4;
  localparam int FAULT_W         = 32;
  localparam int LIMIT_W         = 4;
  localparam int MAX_FRAMES_DEF  = 8;
  localparam logic [LIMIT_W-1:0] FRAME_LIMIT_RESET = 4'd8;

  // broadcast from the top level to every cell of the stack
  typedef struct packed {
    logic              update;
    logic [PAGE_W-1:0] page;
  } lru_bcast_t;

  // per-cell position flags worked out by the top level
  typedef struct packed {
    logic in_range;
    logic below_stop;
  } lru_cell_pos_t;

endpackage

/* hw/rtl/lru_ifaces.sv */
interface lru_req_if;
  import lru_pkg::*;

  logic              valid;
  logic              ready;
  logic [PAGE_W-1:0] page_number;

  modport source (output valid, output page_number, input ready);
  modport sink   (input valid, input page_number, output ready);
endinterface

interface lru_rsp_if;
  import lru_pkg::*;

  logic               valid;
  logic               ready;
  logic               hit;
  logic               evicted_valid;
  logic [PAGE_W-1:0]  evicted_page;
  logic [COUNT_W-1:0] resident_count;
  logic [FAULT_W-1:0] fault_total;

  modport source (output valid, output hit, output evicted_valid, output evicted_page,
                  output resident_count, output fault_total, input ready);
  modport sink   (input valid, input hit, input evicted_valid, input evicted_page,
                  input resident_count, input fault_total, output ready);
endinterface

/* hw/rtl/lru_cell.sv */
module lru_cell (
  input  logic                                clk,
  input  lru_pkg::lru_bcast_t                 bcast,
  input  lru_pkg::lru_cell_pos_t              pos,
  input  logic                                shift_in,
  input  logic [lru_pkg::PAGE_W-1:0]          prev_entry,
  output logic [lru_pkg::PAGE_W-1:0]          entry,
  output logic                                match,
  output logic                                shift_out
);
  import lru_pkg::*;

  assign match     = pos.in_range && (entry == bcast.page);
  // the shift wave stops at the matching cell or at the last cell taking part
  assign shift_out = shift_in && !match && pos.below_stop;

  always_ff @(posedge clk) begin
    if (bcast.update && shift_in) begin
      entry <= prev_entry;
    end
  end

endmodule

/* hw/rtl/lru_page_replacement_core.sv */
// LRU page replacement core. Each accepted page reference is looked up in a row of
// MAX_FRAMES cells holding the resident pages, most recent first; all cells compare
// at once and the hit or new page is placed at the top while the more recent pages
// shift down one cell, all in the cycle of acceptance. One reference is taken per
// cycle while req.ready is high; its result appears in the output register on the
// next cycle. The clock rate is set by the compare and shift chain in the cell row.
// Users write frame_limit via cfg_we/cfg_wdata only while idle; the core does not check.
module lru_page_replacement_core #(
  parameter int MAX_FRAMES = lru_pkg::MAX_FRAMES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [lru_pkg::LIMIT_W-1:0]   cfg_wdata,
  lru_req_if.sink                       req,
  lru_rsp_if.source                     rsp
);
  import lru_pkg::*;

  localparam int OCC_W = $clog2(MAX_FRAMES + 1);
  localparam int LW    = (OCC_W > LIMIT_W) ? OCC_W : LIMIT_W;
  localparam logic [LW-1:0] MAX_L = LW'(MAX_FRAMES);

  logic [LIMIT_W-1:0] frame_limit;
  logic [OCC_W-1:0]   occupancy;
  logic [OCC_W-1:0]   occupancy_next;
  logic [FAULT_W-1:0] fault_counter;
  logic [FAULT_W-1:0] fault_counter_next;

  logic               accept;
  logic [LW-1:0]      lim_eff;
  logic [LW-1:0]      occ_l;
  logic [LW-1:0]      stop;
  logic               push;
  logic               hit_c;
  logic               evict_c;
  logic [PAGE_W-1:0]  evicted_c;

  lru_bcast_t          bcast;
  lru_cell_pos_t       pos     [MAX_FRAMES];
  logic [PAGE_W-1:0]   entries [MAX_FRAMES];
  logic [PAGE_W-1:0]   prev    [MAX_FRAMES];
  logic [MAX_FRAMES:0] shift;
  logic [MAX_FRAMES-1:0] hit_vec;

  assign accept      = req.valid && req.ready;
  assign req.ready   = !rsp.valid || rsp.ready;
  assign bcast.update = accept;
  assign bcast.page   = req.page_number;

  always_comb begin
    lim_eff = LW'(frame_limit);
    if (lim_eff == '0) begin
      lim_eff = LW'(1);
    end else if (lim_eff > MAX_L) begin
      lim_eff = MAX_L;
    end
  end

  assign occ_l   = LW'(occupancy);
  assign push    = occ_l < lim_eff;
  assign hit_c   = |hit_vec;
  assign evict_c = !hit_c && !push;
  // last cell the shift reaches on a miss
  assign stop    = push ? occ_l : (occ_l - LW'(1));

  assign shift[0] = 1'b1;

  for (genvar i = 0; i < MAX_FRAMES; i++) begin : g_cell
    assign pos[i].in_range   = LW'(i) < occ_l;
    assign pos[i].below_stop = LW'(i) < stop;
    if (i == 0) begin : g_top
      assign prev[i] = req.page_number;
    end else begin : g_rest
      assign prev[i] = entries[i-1];
    end

    lru_cell u_cell (
      .clk        (clk),
      .bcast      (bcast),
      .pos        (pos[i]),
      .shift_in   (shift[i]),
      .prev_entry (prev[i]),
      .entry      (entries[i]),
      .match      (hit_vec[i]),
      .shift_out  (shift[i+1])
    );
  end

  // least recent resident page
  always_comb begin
    evicted_c = '0;
    for (int i = 0; i < MAX_FRAMES; i++) begin
      if (LW'(i) == stop) begin
        evicted_c = evicted_c | entries[i];
      end
    end
    if (!evict_c) begin
      evicted_c = '0;
    end
  end

  always_comb begin
    occupancy_next     = occupancy;
    fault_counter_next = fault_counter;
    if (accept && !hit_c) begin
      if (fault_counter != '1) begin
        fault_counter_next = fault_counter + FAULT_W'(1);
      end
      if (push) begin
        occupancy_next = occupancy + OCC_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_limit   <= FRAME_LIMIT_RESET;
      occupancy     <= '0;
      fault_counter <= '0;
      rsp.valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        frame_limit <= cfg_wdata;
      end
      occupancy     <= occupancy_next;
      fault_counter <= fault_counter_next;
      if (accept) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.hit            <= hit_c;
      rsp.evicted_valid  <= evict_c;
      rsp.evicted_page   <= evicted_c;
      rsp.resident_count <= COUNT_W'(occupancy_next);
      rsp.fault_total    <= fault_counter_next;
    end
  end

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    LW'(occupancy) <= MAX_L)
    else $error("occupancy above built depth");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !(rsp.hit && rsp.evicted_valid))
    else $error("hit reported with an eviction");

  a_fault_count: assert property (@(posedge clk) disable iff (rst)
    (accept && !hit_c && fault_counter != '1) |=> fault_counter == $past(fault_counter) + 1'b1)
    else $error("fault counter did not advance on a miss");

  a_evict_keeps_occ: assert property (@(posedge clk) disable iff (rst)
    (accept && evict_c) |=> occupancy == $past(occupancy))
    else $error("occupancy changed on an eviction");

  a_single_match: assert property (@(posedge clk) disable iff (rst)
    accept |-> $onehot0(hit_vec))
    else $error("page resident in more than one cell");

endmodule

/* tb/tb_lru_page_replacement_core.sv */
typedef struct packed {
  logic                         hit;
  logic                         evicted_valid;
  logic [lru_pkg::PAGE_W-1:0]   evicted_page;
  logic [lru_pkg::COUNT_W-1:0]  resident_count;
  logic [lru_pkg::FAULT_W-1:0]  fault_total;
} page_result_t;

class lru_scoreboard;
  localparam int FRAMES = lru_pkg::MAX_FRAMES_DEF;

  logic [lru_pkg::PAGE_W-1:0]  resident[FRAMES];
  int unsigned                 occupied;
  logic [lru_pkg::FAULT_W-1:0] faults;
  logic [lru_pkg::LIMIT_W-1:0] frame_limit;
  page_result_t                pending_results[$];
  int                          mismatches;
  int                          unexpected;
  int                          references;
  int                          hits;
  int                          evictions;

  function new();
    foreach (resident[i]) resident[i] = '0;
    occupied    = 0;
    faults      = '0;
    frame_limit = lru_pkg::FRAME_LIMIT_RESET;
    mismatches  = 0;
    unexpected  = 0;
    references  = 0;
    hits        = 0;
    evictions   = 0;
  endfunction

  function void set_limit(logic [lru_pkg::LIMIT_W-1:0] value);
    frame_limit = value;
  endfunction

  function int pending();
    return pending_results.size();
  endfunction

  // entries above upto move down one place, page lands on top
  function void move_to_top(int unsigned upto, logic [lru_pkg::PAGE_W-1:0] page);
    if (upto >= FRAMES) upto = FRAMES - 1;
    for (int unsigned i = upto; i > 0; i--) resident[i] = resident[i-1];
    resident[0] = page;
  endfunction

  function void note_reference(logic [lru_pkg::PAGE_W-1:0] page);
    int unsigned  usable;
    int unsigned  depth;
    bit           found;
    page_result_t want;
    usable = frame_limit;
    if (usable == 0) usable = 1;
    if (usable > FRAMES) usable = FRAMES;
    found = 0;
    depth = 0;
    for (int unsigned i = 0; i < occupied; i++) begin
      if (!found && resident[i] == page) begin
        found = 1;
        depth = i;
      end
    end
    want = '0;
    if (found) begin
      want.hit = 1'b1;
      hits++;
      move_to_top(depth, page);
    end else begin
      if (faults != '1) faults = faults + 1'b1;
      if (occupied < usable) begin
        move_to_top(occupied, page);
        occupied++;
      end else begin
        want.evicted_valid = 1'b1;
        want.evicted_page  = resident[occupied-1];
        evictions++;
        move_to_top(occupied - 1, page);
      end
    end
    want.resident_count = occupied[lru_pkg::COUNT_W-1:0];
    want.fault_total    = faults;
    references++;
    pending_results.push_back(want);
  endfunction

  function void check_result(page_result_t got);
    page_result_t want;
    if (pending_results.size() == 0) begin
      unexpected++;
      if (mismatches + unexpected <= 10)
        $display("unexpected result: hit=%0b ev=%0b ev_page=%h count=%0d faults=%0d",
                 got.hit, got.evicted_valid, got.evicted_page, got.resident_count,
                 got.fault_total);
      return;
    end
    want = pending_results.pop_front();
    if (got.hit !== want.hit || got.evicted_valid !== want.evicted_valid ||
        got.evicted_page !== want.evicted_page ||
        got.resident_count !== want.resident_count ||
        got.fault_total !== want.fault_total) begin
      mismatches++;
      if (mismatches + unexpected <= 10) begin
        $display("mismatch: exp hit=%0b ev=%0b ev_page=%h count=%0d faults=%0d",
                 want.hit, want.evicted_valid, want.evicted_page, want.resident_count,
                 want.fault_total);
        $display("          got hit=%0b ev=%0b ev_page=%h count=%0d faults=%0d",
                 got.hit, got.evicted_valid, got.evicted_page, got.resident_count,
                 got.fault_total);
      end
    end
  endfunction
endclass

module tb_lru_page_replacement_core;
  import lru_pkg::*;

  localparam int WATCHDOG_CYCLES = 1000;
  localparam int ITEMS_PER_PHASE = 177;

  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic [LIMIT_W-1:0] cfg_wdata;

  lru_req_if req_ch ();
  lru_rsp_if rsp_ch ();

  lru_page_replacement_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  lru_scoreboard   sb;
  logic [PAGE_W-1:0] page_pool[16];
  int                pool_size;
  logic [PAGE_W-1:0] last_page;
  int                send_burst;
  int                recv_burst;
  int                settings_used;
  int                quiet_cycles;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // per-item wait, with occasional runs of back-to-back transactions
  function automatic int draw_wait(ref int burst_left);
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      burst_left = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 8);
  endfunction

  task automatic send_page(logic [PAGE_W-1:0] page);
    int gap;
    gap = draw_wait(send_burst);
    if (gap > 0) begin
      @(negedge clk);
      req_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    req_ch.valid       <= 1'b1;
    req_ch.page_number <= page;
    @(posedge clk);
    while (req_ch.ready !== 1'b1) @(posedge clk);
    sb.note_reference(page);
    last_page = page;
  endtask

  task automatic settle();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_limit(logic [LIMIT_W-1:0] value);
    settle();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    sb.set_limit(value);
    settings_used++;
  endtask

  function automatic logic [PAGE_W-1:0] pick_page();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 80) return page_pool[$urandom_range(0, pool_size - 1)];
    if (roll < 92) return last_page;
    return $urandom();
  endfunction

  // receiving side
  initial begin
    int stall;
    rsp_ch.ready = 1'b0;
    recv_burst   = 0;
    @(negedge rst);
    forever begin
      stall = draw_wait(recv_burst);
      if (stall > 0) begin
        @(negedge clk);
        rsp_ch.ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      rsp_ch.ready <= 1'b1;
      @(posedge clk);
      while (rsp_ch.valid !== 1'b1) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
      sb.check_result('{rsp_ch.hit, rsp_ch.evicted_valid, rsp_ch.evicted_page,
                        rsp_ch.resident_count, rsp_ch.fault_total});
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_CYCLES) begin
        $display("watchdog: no transaction for %0d cycles", WATCHDOG_CYCLES);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    logic [LIMIT_W-1:0] limit_plan[11];
    logic [PAGE_W-1:0]  opening[4];
    logic [PAGE_W-1:0]  partial[5];
    logic [PAGE_W-1:0]  filling[8];
    int                 leftover;
    int                 failures;

    sb                 = new();
    rst                = 1'b1;
    cfg_we             = 1'b0;
    cfg_wdata          = '0;
    req_ch.valid       = 1'b0;
    req_ch.page_number = '0;
    send_burst         = 0;
    settings_used      = 0;
    quiet_cycles       = 0;
    last_page          = '0;
    pool_size          = 1;
    limit_plan = '{4'd1, 4'd8, 4'd4, 4'd9, 4'd0, 4'd15, 4'd6, 4'd2, 4'd7, 4'd3, 4'd5};
    opening    = '{32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0};
    partial    = '{32'h1, 32'h2, 32'h0, 32'h5, 32'h2};
    filling    = '{32'h6, 32'h7, 32'h8, 32'h9, 32'hAAAA_AAAA, 32'h0, 32'hFFFF_FFFF,
                   32'h5555_5555};

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // zero limit acts as a single frame
    write_limit(4'd0);
    foreach (opening[i]) send_page(opening[i]);
    // partial fill, hit on the oldest entry, then eviction
    write_limit(4'd3);
    foreach (partial[i]) send_page(partial[i]);
    // limit above the built depth is capped, stack fills and overflows
    write_limit(4'd15);
    foreach (filling[i]) send_page(filling[i]);
    // lowered below occupancy: nothing dropped, faults evict the oldest
    write_limit(4'd2);
    send_page(32'h8000_0000);
    send_page(32'h8000_0000);

    foreach (limit_plan[p]) begin
      write_limit(limit_plan[p]);
      pool_size = $urandom_range(2, 16);
      for (int i = 0; i < pool_size; i++) page_pool[i] = $urandom();
      repeat (ITEMS_PER_PHASE) send_page(pick_page());
    end

    settle();
    repeat (4) @(posedge clk);
    leftover = sb.pending();
    if (leftover != 0) $display("%0d expected results never arrived", leftover);
    failures = sb.mismatches + sb.unexpected + leftover;
    $display("%0d page references over %0d frame-limit settings: %0d hits, %0d evictions",
             sb.references, settings_used, sb.hits, sb.evictions);
    $display("%0d mismatches, %0d unexpected results", sb.mismatches, sb.unexpected);
    if (failures == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
